[rtl/particle_cell_binning_macros.svh]
// Assertion macros shared by the particle cell binning modules.
`ifndef PARTICLE_CELL_BINNING_MACROS_SVH
`define PARTICLE_CELL_BINNING_MACROS_SVH

`ifndef SYNTHESIS

`define PCB_ASSERT_IMP(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("particle_cell_binning: same-cycle check failed");

`define PCB_ASSERT_NXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("particle_cell_binning: next-cycle check failed");

`else

`define PCB_ASSERT_IMP(name, clk, rst_n, ante, cons)

`define PCB_ASSERT_NXT(name, clk, rst_n, ante, cons)

`endif

`endif

[rtl/pcb_pkg.sv]
// Types and constants shared by the particle cell binning modules.
package pcb_pkg;

	localparam int DIV_W      = 31;
	localparam int CELL_MAX_W = 18;
	localparam int ID_W       = 16;
	localparam int POS_W      = 32;
	localparam int EXT_W      = 15;
	localparam int CELLS_W    = 5;
	localparam int IDX_W      = 12;
	localparam int SLOT_W     = 5;
	localparam int ST_W       = 2;
	localparam int OP_W       = 2;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 31;
	localparam int CMDQ_DEPTH = 2;

	typedef logic [DIV_W-1:0]      quo_t;
	typedef logic [CELL_MAX_W-1:0] cell_t;

	localparam logic [ST_W-1:0] ST_OK     = 2'd0;
	localparam logic [ST_W-1:0] ST_DOMAIN = 2'd1;
	localparam logic [ST_W-1:0] ST_GRID   = 2'd2;
	localparam logic [ST_W-1:0] ST_FULL   = 2'd3;

	localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
	localparam logic [OP_W-1:0] OP_BIN    = 2'd1;
	localparam logic [OP_W-1:0] OP_REJECT = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_CELL_SIZE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_EXTENT_X  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_EXTENT_Y  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_EXTENT_Z  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CELLS_X   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_CELLS_Y   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_CELLS_Z   = 3'd6;

	localparam logic [DIV_W-1:0]   RST_CELL_SIZE = 31'd65536;
	localparam logic [EXT_W-1:0]   RST_EXTENT    = 15'd16;
	localparam logic [CELLS_W-1:0] RST_CELLS     = 5'd16;

	typedef struct packed {
		logic                    kind;
		logic [ID_W-1:0]         particle_id;
		logic signed [POS_W-1:0] pos_x;
		logic signed [POS_W-1:0] pos_y;
		logic signed [POS_W-1:0] pos_z;
	} item_t;

	typedef struct packed {
		logic [IDX_W-1:0]  cell_index;
		logic [SLOT_W-1:0] slot;
		logic [ST_W-1:0]   status;
	} res_t;

	typedef struct packed {
		logic [DIV_W-1:0]   cell_size;
		logic [EXT_W-1:0]   extent_x;
		logic [EXT_W-1:0]   extent_y;
		logic [EXT_W-1:0]   extent_z;
		logic [CELLS_W-1:0] cells_x;
		logic [CELLS_W-1:0] cells_y;
		logic [CELLS_W-1:0] cells_z;
	} cfg_t;

	// cell_idx holds the linear index of a grid of up to 64 cells per side
	typedef struct packed {
		logic [OP_W-1:0] op;
		logic [ST_W-1:0] status;
		cell_t           cell_idx;
		logic [ID_W-1:0] id;
	} cmd_t;

endpackage

[rtl/pcb_div.sv]
// Bit-serial restoring divider, one quotient bit per cycle.
module pcb_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [pcb_pkg::DIV_W-1:0] dividend,
	input  logic [pcb_pkg::DIV_W-1:0] divisor,
	output logic                      done,
	output logic [pcb_pkg::DIV_W-1:0] quotient
);

	localparam int W     = pcb_pkg::DIV_W;
	localparam int CNT_W = $clog2(W);
	localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(W - 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [W-1:0]     rem_q;
	logic [W-1:0]     quo_q;
	logic [W:0]       trial;
	logic [W:0]       diff;
	logic             fits;

	assign trial = {rem_q, quo_q[W-1]};
	assign diff  = trial - {1'b0, divisor};
	assign fits  = trial >= {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST_STEP) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= fits ? diff[W-1:0] : trial[W-1:0];
			quo_q <= {quo_q[W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

[rtl/pcb_front.sv]
// Front end: accepts items, checks the domain and cell size, divides and checks the grid.
`include "particle_cell_binning_macros.svh"

module pcb_front #(
	parameter int GRID_SIDE = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  pcb_pkg::cfg_t  cfg,
	input  logic           hold,
	input  logic           push,
	output logic           full,
	input  pcb_pkg::item_t item,
	output logic           cmd_valid,
	input  logic           cmd_ready,
	output pcb_pkg::cmd_t  cmd
);

	localparam int COORD_W = $clog2(GRID_SIDE);
	localparam int W       = pcb_pkg::DIV_W;
	localparam pcb_pkg::quo_t GRID_LIM = pcb_pkg::quo_t'(GRID_SIDE);

	localparam logic [1:0] F_IDLE = 2'd0;
	localparam logic [1:0] F_DIV  = 2'd1;
	localparam logic [1:0] F_PUSH = 2'd2;

	logic [1:0]     state_q;
	pcb_pkg::cmd_t  cmd_q;
	logic           accept;
	logic           out_dom;
	logic           size_zero;
	logic           dv_start;
	logic [2:0]     dv_done;
	logic [W-1:0]   qx, qy, qz;
	logic [W-1:0]   lim_x, lim_y, lim_z;
	logic           out_grid;
	pcb_pkg::cell_t cell_lin;

	assign full   = (state_q != F_IDLE) | hold;
	assign accept = push & ~full;

	assign out_dom =
		item.pos_x[pcb_pkg::POS_W-1] | (item.pos_x[W-1:0] >= {cfg.extent_x, 16'h0000}) |
		item.pos_y[pcb_pkg::POS_W-1] | (item.pos_y[W-1:0] >= {cfg.extent_y, 16'h0000}) |
		item.pos_z[pcb_pkg::POS_W-1] | (item.pos_z[W-1:0] >= {cfg.extent_z, 16'h0000});
	assign size_zero = (cfg.cell_size == '0);
	assign dv_start  = accept & item.kind & ~out_dom & ~size_zero;

	pcb_div u_div_x (
		.clk(clk), .arst_n(arst_n), .start(dv_start), .dividend(item.pos_x[W-1:0]),
		.divisor(cfg.cell_size), .done(dv_done[0]), .quotient(qx)
	);
	pcb_div u_div_y (
		.clk(clk), .arst_n(arst_n), .start(dv_start), .dividend(item.pos_y[W-1:0]),
		.divisor(cfg.cell_size), .done(dv_done[1]), .quotient(qy)
	);
	pcb_div u_div_z (
		.clk(clk), .arst_n(arst_n), .start(dv_start), .dividend(item.pos_z[W-1:0]),
		.divisor(cfg.cell_size), .done(dv_done[2]), .quotient(qz)
	);

	assign lim_x = (pcb_pkg::quo_t'(cfg.cells_x) > GRID_LIM) ? GRID_LIM :
		pcb_pkg::quo_t'(cfg.cells_x);
	assign lim_y = (pcb_pkg::quo_t'(cfg.cells_y) > GRID_LIM) ? GRID_LIM :
		pcb_pkg::quo_t'(cfg.cells_y);
	assign lim_z = (pcb_pkg::quo_t'(cfg.cells_z) > GRID_LIM) ? GRID_LIM :
		pcb_pkg::quo_t'(cfg.cells_z);
	assign out_grid = (qx >= lim_x) | (qy >= lim_y) | (qz >= lim_z);

	assign cell_lin =
		pcb_pkg::cell_t'(qx[COORD_W-1:0]) * pcb_pkg::cell_t'(GRID_SIDE * GRID_SIDE) +
		pcb_pkg::cell_t'(qy[COORD_W-1:0]) * pcb_pkg::cell_t'(GRID_SIDE) +
		pcb_pkg::cell_t'(qz[COORD_W-1:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			case (state_q)
				F_IDLE: begin
					if (accept) begin
						state_q <= dv_start ? F_DIV : F_PUSH;
					end
				end
				F_DIV: begin
					if (dv_done[0]) begin
						state_q <= F_PUSH;
					end
				end
				F_PUSH: begin
					if (cmd_ready) begin
						state_q <= F_IDLE;
					end
				end
				default: begin
					state_q <= F_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q.id       <= item.particle_id;
			cmd_q.cell_idx <= '0;
			cmd_q.status   <= pcb_pkg::ST_OK;
			if (!item.kind) begin
				cmd_q.op <= pcb_pkg::OP_CLEAR;
			end else if (out_dom) begin
				cmd_q.op     <= pcb_pkg::OP_REJECT;
				cmd_q.status <= pcb_pkg::ST_DOMAIN;
			end else if (size_zero) begin
				cmd_q.op     <= pcb_pkg::OP_REJECT;
				cmd_q.status <= pcb_pkg::ST_GRID;
			end else begin
				cmd_q.op <= pcb_pkg::OP_BIN;
			end
		end else if (state_q == F_DIV && dv_done[0]) begin
			if (out_grid) begin
				cmd_q.op     <= pcb_pkg::OP_REJECT;
				cmd_q.status <= pcb_pkg::ST_GRID;
			end else begin
				cmd_q.op       <= pcb_pkg::OP_BIN;
				cmd_q.cell_idx <= cell_lin;
			end
		end
	end

	assign cmd_valid = (state_q == F_PUSH);
	assign cmd       = cmd_q;

	`PCB_ASSERT_IMP(a_div_lockstep, clk, arst_n, dv_done[0], dv_done[1] && dv_done[2])
	`PCB_ASSERT_NXT(a_accept_blocks, clk, arst_n, push && !full, full)

endmodule

[rtl/pcb_cmd_fifo.sv]
// Short command queue between the front and back ends.
module pcb_cmd_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  pcb_pkg::cmd_t in_cmd,
	output logic          out_valid,
	input  logic          out_ready,
	output pcb_pkg::cmd_t out_cmd
);

	localparam int DEPTH = pcb_pkg::CMDQ_DEPTH;
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	pcb_pkg::cmd_t    slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             wr;
	logic             rd;

	assign in_ready  = (cnt_q != FULL_CNT);
	assign out_valid = (cnt_q != '0);
	assign wr        = in_valid & in_ready;
	assign rd        = out_valid & out_ready;
	assign out_cmd   = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr && !rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (rd && !wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr) begin
			slot_q[wr_ptr_q] <= in_cmd;
		end
	end

endmodule

[rtl/pcb_back.sv]
// Back end: cell count read-modify-write, member store, clearing sweep, result word.
`include "particle_cell_binning_macros.svh"

module pcb_back #(
	parameter int GRID_SIDE = 16,
	parameter int CELL_CAP  = 32,
	parameter int ID_BITS   = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_ready,
	input  pcb_pkg::cmd_t cmd,
	output logic          init_busy,
	output logic          empty,
	input  logic          pop,
	output pcb_pkg::res_t result
);

	localparam int NUM_CELLS = GRID_SIDE * GRID_SIDE * GRID_SIDE;
	localparam int CELL_AW   = $clog2(NUM_CELLS);
	localparam int MEM_DEPTH = NUM_CELLS * CELL_CAP;
	localparam int MEM_AW    = $clog2(MEM_DEPTH);
	localparam int CNT_W     = $clog2(CELL_CAP + 1);
	localparam logic [CELL_AW-1:0] LAST_CELL = CELL_AW'(NUM_CELLS - 1);
	localparam logic [CNT_W-1:0]   CAP_CNT   = CNT_W'(CELL_CAP);

	localparam logic [1:0] B_IDLE  = 2'd0;
	localparam logic [1:0] B_READ  = 2'd1;
	localparam logic [1:0] B_SWEEP = 2'd2;

	logic [CNT_W-1:0]   cnt_mem [NUM_CELLS];
	logic [ID_BITS-1:0] id_mem  [MEM_DEPTH];

	logic [1:0]                 state_q;
	logic [CELL_AW-1:0]         sweep_q;
	logic                       report_q;
	logic                       out_valid_q;
	pcb_pkg::res_t              out_q;
	logic [CELL_AW-1:0]         cell_q;
	logic [pcb_pkg::ID_W-1:0]   id_q;
	logic [CNT_W-1:0]           cnt_rd_q;
	logic                       take;
	logic                       rd_en;
	logic                       cell_full;
	logic                       sweep_last;
	logic                       wr_en;
	logic [CELL_AW-1:0]         wr_addr;
	logic [CNT_W-1:0]           wr_data;
	logic                       mem_wr;
	logic [MEM_AW-1:0]          mem_addr;
	logic                       set_out;
	pcb_pkg::res_t              out_next;

	assign cmd_ready  = (state_q == B_IDLE) & ~out_valid_q;
	assign take       = cmd_valid & cmd_ready;
	assign rd_en      = take & (cmd.op == pcb_pkg::OP_BIN);
	assign cell_full  = (cnt_rd_q >= CAP_CNT);
	assign sweep_last = (sweep_q == LAST_CELL);
	assign init_busy  = (state_q == B_SWEEP) & ~report_q;

	assign mem_wr   = (state_q == B_READ) & ~cell_full;
	assign wr_en    = (state_q == B_SWEEP) | mem_wr;
	assign wr_addr  = (state_q == B_SWEEP) ? sweep_q : cell_q;
	assign wr_data  = (state_q == B_SWEEP) ? '0 : cnt_rd_q + 1'b1;
	assign mem_addr = MEM_AW'(cell_q) * MEM_AW'(CELL_CAP) + MEM_AW'(cnt_rd_q);

	always_ff @(posedge clk) begin
		if (rd_en) begin
			cnt_rd_q <= cnt_mem[cmd.cell_idx[CELL_AW-1:0]];
		end
		if (wr_en) begin
			cnt_mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_wr) begin
			id_mem[mem_addr] <= ID_BITS'(id_q);
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cell_q <= cmd.cell_idx[CELL_AW-1:0];
			id_q   <= cmd.id;
		end
	end

	always_comb begin
		set_out         = 1'b0;
		out_next        = '0;
		out_next.status = pcb_pkg::ST_OK;
		case (state_q)
			B_IDLE: begin
				if (take && cmd.op != pcb_pkg::OP_BIN && cmd.op != pcb_pkg::OP_CLEAR) begin
					set_out         = 1'b1;
					out_next.status = cmd.status;
				end
			end
			B_READ: begin
				set_out = 1'b1;
				if (cell_full) begin
					out_next.status = pcb_pkg::ST_FULL;
				end else begin
					out_next.cell_index = pcb_pkg::IDX_W'(cell_q);
					out_next.slot       = pcb_pkg::SLOT_W'(cnt_rd_q);
				end
			end
			B_SWEEP: begin
				set_out = sweep_last & report_q;
			end
			default: begin
				set_out = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_SWEEP;
			sweep_q     <= '0;
			report_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (set_out) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				B_IDLE: begin
					if (take && cmd.op == pcb_pkg::OP_BIN) begin
						state_q <= B_READ;
					end else if (take && cmd.op == pcb_pkg::OP_CLEAR) begin
						state_q  <= B_SWEEP;
						sweep_q  <= '0;
						report_q <= 1'b1;
					end
				end
				B_READ: begin
					state_q <= B_IDLE;
				end
				B_SWEEP: begin
					sweep_q <= sweep_q + 1'b1;
					if (sweep_last) begin
						state_q <= B_IDLE;
					end
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (set_out) begin
			out_q <= out_next;
		end
	end

	assign empty  = ~out_valid_q;
	assign result = out_q;

	`PCB_ASSERT_NXT(a_read_gives_word, clk, arst_n, state_q == B_READ, out_valid_q && state_q == B_IDLE)
	`PCB_ASSERT_IMP(a_count_bound, clk, arst_n, state_q == B_READ, cnt_rd_q <= CAP_CNT)

endmodule

[rtl/particle_cell_binning.sv]
// Top level of the particle cell binning block: configuration registers and wiring.
// A bin word holds the front end from the accepting edge through three bit-serial dividers
// that run side by side on the cell size, then a grid check, then the hand-off of the
// command to the queue, which waits while the queue is full. The back end then reads the
// cell count, and in its next state writes the count back and loads the result word.
// A word rejected at the domain or cell-size check skips the dividers, and the back end
// loads its result word as it takes the command. A clear word sweeps the count memory one
// cell a cycle over GRID_SIDE cubed cells (4096 at the default), and its result follows the
// last cell. The same sweep runs after reset, with full held high until it ends.
// Front and back are parted by a two-entry command queue, and results wait in an output
// register, so a new word is taken while a result is still to be popped.
module particle_cell_binning #(
	parameter int GRID_SIDE = 16,
	parameter int CELL_CAP  = 32,
	parameter int ID_BITS   = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [pcb_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [pcb_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           push,
	output logic                           full,
	input  pcb_pkg::item_t                 item,
	input  logic                           pop,
	output logic                           empty,
	output pcb_pkg::res_t                  result
);

	pcb_pkg::cfg_t cfg_q;
	pcb_pkg::cmd_t f_cmd;
	pcb_pkg::cmd_t b_cmd;
	logic          f_valid, f_ready;
	logic          b_valid, b_ready;
	logic          init_busy;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cell_size <= pcb_pkg::RST_CELL_SIZE;
			cfg_q.extent_x  <= pcb_pkg::RST_EXTENT;
			cfg_q.extent_y  <= pcb_pkg::RST_EXTENT;
			cfg_q.extent_z  <= pcb_pkg::RST_EXTENT;
			cfg_q.cells_x   <= pcb_pkg::RST_CELLS;
			cfg_q.cells_y   <= pcb_pkg::RST_CELLS;
			cfg_q.cells_z   <= pcb_pkg::RST_CELLS;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				pcb_pkg::REG_CELL_SIZE: cfg_q.cell_size <= cfg_data;
				pcb_pkg::REG_EXTENT_X:  cfg_q.extent_x  <= cfg_data[pcb_pkg::EXT_W-1:0];
				pcb_pkg::REG_EXTENT_Y:  cfg_q.extent_y  <= cfg_data[pcb_pkg::EXT_W-1:0];
				pcb_pkg::REG_EXTENT_Z:  cfg_q.extent_z  <= cfg_data[pcb_pkg::EXT_W-1:0];
				pcb_pkg::REG_CELLS_X:   cfg_q.cells_x   <= cfg_data[pcb_pkg::CELLS_W-1:0];
				pcb_pkg::REG_CELLS_Y:   cfg_q.cells_y   <= cfg_data[pcb_pkg::CELLS_W-1:0];
				pcb_pkg::REG_CELLS_Z:   cfg_q.cells_z   <= cfg_data[pcb_pkg::CELLS_W-1:0];
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	pcb_front #(
		.GRID_SIDE(GRID_SIDE)
	) u_front (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q), .hold(init_busy),
		.push(push), .full(full), .item(item),
		.cmd_valid(f_valid), .cmd_ready(f_ready), .cmd(f_cmd)
	);

	pcb_cmd_fifo u_cmdq (
		.clk(clk), .arst_n(arst_n),
		.in_valid(f_valid), .in_ready(f_ready), .in_cmd(f_cmd),
		.out_valid(b_valid), .out_ready(b_ready), .out_cmd(b_cmd)
	);

	pcb_back #(
		.GRID_SIDE(GRID_SIDE),
		.CELL_CAP(CELL_CAP),
		.ID_BITS(ID_BITS)
	) u_back (
		.clk(clk), .arst_n(arst_n),
		.cmd_valid(b_valid), .cmd_ready(b_ready), .cmd(b_cmd),
		.init_busy(init_busy), .empty(empty), .pop(pop), .result(result)
	);

endmodule
